[hdl/byte_stream_lexer_assert.svh]
// assertion macros used by the lexer rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef BYTE_STREAM_LEXER_ASSERT_SVH
`define BYTE_STREAM_LEXER_ASSERT_SVH

// same-cycle implication
`define BSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bsl_pkg.sv]
// types, codes and helper functions for the byte stream lexer
// no dependencies
package bsl_pkg;

	// token kinds
	localparam logic [3:0] TK_EOF       = 4'd0;
	localparam logic [3:0] TK_IDENT     = 4'd1;
	localparam logic [3:0] TK_VAR       = 4'd2;
	localparam logic [3:0] TK_WRITE     = 4'd3;
	localparam logic [3:0] TK_NUMBER    = 4'd4;
	localparam logic [3:0] TK_STRING    = 4'd5;
	localparam logic [3:0] TK_LPAREN    = 4'd6;
	localparam logic [3:0] TK_RPAREN    = 4'd7;
	localparam logic [3:0] TK_PLUS      = 4'd8;
	localparam logic [3:0] TK_MINUS     = 4'd9;
	localparam logic [3:0] TK_STAR      = 4'd10;
	localparam logic [3:0] TK_SLASH     = 4'd11;
	localparam logic [3:0] TK_EQUAL     = 4'd12;
	localparam logic [3:0] TK_GREATER   = 4'd13;
	localparam logic [3:0] TK_SEMICOLON = 4'd14;
	localparam logic [3:0] TK_ERROR     = 4'd15;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
	localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

	// keyword match progress
	localparam logic [2:0] KW_NONE = 3'd0;
	localparam logic [2:0] KW_V    = 3'd1;
	localparam logic [2:0] KW_VA   = 3'd2;
	localparam logic [2:0] KW_VAR  = 3'd3;
	localparam logic [2:0] KW_W    = 3'd4;
	localparam logic [2:0] KW_WR   = 3'd5;
	localparam logic [2:0] KW_WRI  = 3'd6;
	localparam logic [2:0] KW_WRIT = 3'd7;

	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_LF         = 8'h0a;
	localparam logic [7:0] CH_CR         = 8'h0d;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

	localparam logic [15:0] LINE_MAX = 16'hffff;

	// result queue depth, power of two
	localparam int OUT_DEPTH = 4;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [15:0] start_pos;
		logic [15:0] token_length;
		logic [15:0] line_number;
		logic [1:0]  error_kind;
		logic        last;
	} tok_t;

	// up to two tokens produced by one byte
	typedef struct packed {
		logic [1:0] n;
		tok_t       r0;
		tok_t       r1;
	} scan_out_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [3:0] punct_kind(input logic [7:0] c);
		logic [3:0] k;
		case (c)
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			"+":     k = TK_PLUS;
			"-":     k = TK_MINUS;
			"*":     k = TK_STAR;
			"/":     k = TK_SLASH;
			"=":     k = TK_EQUAL;
			">":     k = TK_GREATER;
			";":     k = TK_SEMICOLON;
			default: k = TK_EOF;
		endcase
		return k;
	endfunction

	// len_is4: identifier holds four bytes before c is added
	function automatic logic [2:0] kw_next(input logic [2:0] prog, input logic len_is4,
			input logic [7:0] c);
		logic [2:0] p;
		case (prog)
			KW_V:    p = (c == "a") ? KW_VA : KW_NONE;
			KW_VA:   p = (c == "r") ? KW_VAR : KW_NONE;
			KW_W:    p = (c == "r") ? KW_WR : KW_NONE;
			KW_WR:   p = (c == "i") ? KW_WRI : KW_NONE;
			KW_WRI:  p = (c == "t") ? KW_WRIT : KW_NONE;
			KW_WRIT: p = (len_is4 && c == "e") ? KW_WRIT : KW_NONE;
			default: p = KW_NONE;
		endcase
		return p;
	endfunction

	function automatic logic [15:0] line_inc(input logic [15:0] v);
		return (v == LINE_MAX) ? v : v + 16'd1;
	endfunction

endpackage

[hdl/bsl_scan.sv]
// scanner state and per-byte token logic for the byte stream lexer
// depends on bsl_pkg
module bsl_scan import bsl_pkg::*; #(
	parameter int POS_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       take,
	output scan_out_t  res
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUM,
		MODE_STR
	} mode_t;

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	mode_t               mode_q, mode_d;
	logic [POS_BITS-1:0] start_q, start_d;
	logic [POS_BITS-1:0] len_q, len_d;
	logic [POS_BITS-1:0] pos_q;
	logic [15:0]         line_q, line_d;
	logic [2:0]          kw_q, kw_d;
	logic                ended;

	// idle-mode scan of the byte
	mode_t               i_mode;
	logic [POS_BITS-1:0] i_start, i_len;
	logic [15:0]         i_line;
	logic [2:0]          i_kw;
	logic                i_emit, i_end;
	tok_t                i_tok, cur_tok;

	logic [POS_BITS-1:0] len_inc;
	logic [POS_BITS+15:0] pos_ext, start_ext, len_ext, len_inc_ext;
	logic [3:0]          id_kind;

	assign len_inc     = (len_q == POS_MAX) ? len_q : len_q + 1'b1;
	assign pos_ext     = {16'd0, pos_q};
	assign start_ext   = {16'd0, start_q};
	assign len_ext     = {16'd0, len_q};
	assign len_inc_ext = {16'd0, len_inc};

	always_comb begin
		if (kw_q == KW_VAR && len_q == POS_BITS'(3))
			id_kind = TK_VAR;
		else if (kw_q == KW_WRIT && len_q == POS_BITS'(5))
			id_kind = TK_WRITE;
		else
			id_kind = TK_IDENT;
	end

	always_comb begin
		i_mode  = MODE_IDLE;
		i_start = start_q;
		i_len   = len_q;
		i_line  = line_q;
		i_kw    = kw_q;
		i_emit  = 1'b0;
		i_end   = 1'b0;
		i_tok   = '{token_kind: TK_EOF, start_pos: pos_ext[15:0], token_length: 16'd0,
			line_number: line_q, error_kind: ERR_NONE, last: 1'b0};
		if (ch == CH_NUL) begin
			i_emit = 1'b1;
			i_end  = 1'b1;
		end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
			i_mode = MODE_IDLE;
		end else if (ch == CH_LF) begin
			i_line = line_inc(line_q);
		end else if (is_alpha(ch)) begin
			i_mode  = MODE_IDENT;
			i_start = pos_q;
			i_len   = POS_BITS'(1);
			i_kw    = (ch == "v") ? KW_V : (ch == "w") ? KW_W : KW_NONE;
		end else if (is_digit(ch)) begin
			i_mode  = MODE_NUM;
			i_start = pos_q;
			i_len   = POS_BITS'(1);
		end else if (ch == CH_QUOTE) begin
			i_mode  = MODE_STR;
			i_start = pos_q;
			i_len   = POS_BITS'(1);
		end else begin
			i_emit = 1'b1;
			i_tok.token_length = 16'd1;
			if (punct_kind(ch) != TK_EOF) begin
				i_tok.token_kind = punct_kind(ch);
			end else begin
				i_tok.token_kind = TK_ERROR;
				i_tok.error_kind = ERR_UNEXPECTED;
			end
		end
	end

	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		len_d   = len_q;
		line_d  = line_q;
		kw_d    = kw_q;
		ended   = 1'b0;
		res     = '0;
		cur_tok = '{token_kind: TK_IDENT, start_pos: start_ext[15:0],
			token_length: len_ext[15:0], line_number: line_q, error_kind: ERR_NONE,
			last: 1'b0};
		unique case (mode_q)
			MODE_IDENT, MODE_NUM: begin
				if (is_digit(ch) || (mode_q == MODE_IDENT && is_alpha(ch))) begin
					len_d = len_inc;
					if (mode_q == MODE_IDENT)
						kw_d = kw_next(kw_q, len_q == POS_BITS'(4), ch);
				end else begin
					// close the pending token, then scan the byte afresh
					cur_tok.token_kind = (mode_q == MODE_IDENT) ? id_kind : TK_NUMBER;
					res.r0  = cur_tok;
					res.r1  = i_tok;
					res.n   = i_emit ? 2'd2 : 2'd1;
					mode_d  = i_mode;
					start_d = i_start;
					len_d   = i_len;
					line_d  = i_line;
					kw_d    = i_kw;
					ended   = i_end;
				end
			end
			MODE_STR: begin
				if (ch == CH_NUL) begin
					cur_tok.token_kind = TK_ERROR;
					cur_tok.error_kind = ERR_UNTERM_STR;
					res.r0 = cur_tok;
					res.r1 = i_tok;
					res.n  = 2'd2;
					ended  = 1'b1;
				end else begin
					len_d = len_inc;
					if (ch == CH_LF)
						line_d = line_inc(line_q);
					if (ch == CH_QUOTE) begin
						cur_tok.token_kind   = TK_STRING;
						cur_tok.token_length = len_inc_ext[15:0];
						res.r0 = cur_tok;
						res.n  = 2'd1;
						mode_d = MODE_IDLE;
					end
				end
			end
			MODE_IDLE: begin
				res.r0  = i_tok;
				res.n   = i_emit ? 2'd1 : 2'd0;
				mode_d  = i_mode;
				start_d = i_start;
				len_d   = i_len;
				line_d  = i_line;
				kw_d    = i_kw;
				ended   = i_end;
			end
			default: mode_d = MODE_IDLE;
		endcase
		// mark the final token of this byte
		if (res.n == 2'd2)
			res.r1.last = 1'b1;
		else if (res.n == 2'd1)
			res.r0.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			line_q  <= 16'd1;
			kw_q    <= KW_NONE;
		end else if (take) begin
			if (ended) begin
				mode_q  <= MODE_IDLE;
				start_q <= '0;
				len_q   <= '0;
				pos_q   <= '0;
				line_q  <= 16'd1;
				kw_q    <= KW_NONE;
			end else begin
				mode_q  <= mode_d;
				start_q <= start_d;
				len_q   <= len_d;
				pos_q   <= (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
				line_q  <= line_d;
				kw_q    <= kw_d;
			end
		end
	end

endmodule

[hdl/bsl_out_fifo.sv]
// small result queue taking up to two tokens per cycle, giving one per beat
// depends on bsl_pkg and byte_stream_lexer_assert.svh
`include "byte_stream_lexer_assert.svh"

module bsl_out_fifo import bsl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_out_t push,
	input  logic      pop,
	output logic      room2,
	output logic      valid,
	output tok_t      head
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	tok_t             mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign wr_nx  = wr_q + 1'b1;
	assign valid  = cnt_q != '0;
	assign head   = mem_q[rd_q];
	assign do_pop = pop && valid;
	assign room2  = cnt_q <= CNT_W'(OUT_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wr_nx] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.n);
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(do_pop);
		end
	end

	`BSL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(OUT_DEPTH), "result queue overfilled")
	`BSL_ASSERT_NEXT(a_two_push, push.n == 2'd2 && !do_pop,
		cnt_q == $past(cnt_q) + CNT_W'(2), "double push lost a token")
	`BSL_ASSERT_NEXT(a_pop_only, push.n == 2'd0 && do_pop,
		cnt_q == $past(cnt_q) - CNT_W'(1) && rd_q == $past(rd_q) + 1'b1,
		"pop did not advance the queue")

endmodule

[hdl/byte_stream_lexer.sv]
// top level of the byte stream lexer: input and output stream channels
// depends on bsl_pkg, bsl_scan and bsl_out_fifo
//
// Source text arrives one byte per beat on the s_ channel; a zero byte ends
// the source. Tokens leave on the m_ channel, one per beat, with the kind
// and error code in m_tuser and start, length and line in m_tdata. m_tlast
// marks the final token caused by one input byte.
// A token enters the queue when the byte beat that causes it is taken. One
// byte is taken every cycle while s_tready is high. A byte that yields two
// tokens queues both in order; such a byte always follows one that yields at
// most one, so a receiver that is always ready never holds the input back.
// The queue holds four tokens; s_tready drops while fewer than two slots
// are free, so a stalled receiver holds the input back without loss.
// After end of source the scanner returns to its reset state: position 0,
// line 1. Reset clears the scanner and empties the queue.
module byte_stream_lexer import bsl_pkg::*; #(
	parameter int POS_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // start_pos, token_length, line_number
	output logic [5:0]  m_tuser,   // token_kind, error_kind
	output logic        m_tlast
);

	logic      take;
	scan_out_t scan_res, push;
	tok_t      head;

	assign take = s_tvalid && s_tready;

	bsl_scan #(
		.POS_BITS(POS_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ch     (s_tdata),
		.take   (take),
		.res    (scan_res)
	);

	always_comb begin
		push = scan_res;
		if (!take)
			push.n = 2'd0;
	end

	bsl_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (m_tready),
		.room2  (s_tready),
		.valid  (m_tvalid),
		.head   (head)
	);

	assign m_tdata = {head.line_number, head.token_length, head.start_pos};
	assign m_tuser = {head.error_kind, head.token_kind};
	assign m_tlast = head.last;

endmodule
